// File: sv/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define GBMA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication into the next cycle, disabled during reset.
`define GBMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/gbma_pkg.sv
// Types, constants and codes of the grid binning mean accumulator.
package gbma_pkg;

    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 128;
    localparam int CELL_IDX_W   = 20;
    localparam int VAL_W        = 32;
    localparam int SUM_W        = 56;
    localparam int CNT_W        = 24;
    localparam int CFG_IDX_W    = 3;
    localparam int GRID_W       = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 3'd5;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_EMPTY,
        OP_ADD,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [CELL_IDX_W-1:0]   idx;
        logic signed [VAL_W-1:0] value;
        logic                    dropped;
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0] mean_value;
        logic                    cell_empty;
        logic [CNT_W-1:0]        cell_count;
        logic                    sample_dropped;
    } t_res;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_SEND
    } t_fstate;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_READ,
        BS_EXEC,
        BS_DIV,
        BS_DONE
    } t_bstate;

endpackage

// File: sv/gbma_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module gbma_div #(
    parameter int NW = 32,
    parameter int DW = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_sh;
    logic          w_ge;
    logic [DW:0]   w_diff;

    assign w_sh   = {r_rem, r_quo[NW-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_quo <= {r_quo[NW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: sv/gbma_front.sv
// Front end: configuration registers, bin index division and item classification.
module gbma_front #(
    parameter int MAX_COLS = gbma_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gbma_pkg::DEF_MAX_ROWS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [gbma_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [gbma_pkg::VAL_W-1:0]             i_cfg_data,
    input  logic                                   i_take,
    input  logic [1:0]                             i_func,
    input  logic signed [gbma_pkg::VAL_W-1:0]      i_x_pos,
    input  logic signed [gbma_pkg::VAL_W-1:0]      i_y_pos,
    input  logic signed [gbma_pkg::VAL_W-1:0]      i_sample_value,
    input  logic [6:0]                             i_read_col,
    input  logic [6:0]                             i_read_row,
    input  logic                                   i_q_full,
    output logic                                   o_busy,
    output logic                                   o_push,
    output gbma_pkg::t_cmd                         o_cmd
);

    localparam logic [gbma_pkg::GRID_W-1:0] MC = gbma_pkg::GRID_W'(MAX_COLS);
    localparam logic [gbma_pkg::GRID_W-1:0] MR = gbma_pkg::GRID_W'(MAX_ROWS);

    gbma_pkg::t_fstate r_state, n_state;
    gbma_pkg::t_cmd    r_cmd;

    logic [31:0] r_x_min, r_y_min;
    logic [30:0] r_x_w, r_y_w;
    logic [7:0]  r_ncols, r_nrows;

    logic [gbma_pkg::GRID_W-1:0] w_cols, w_rows;
    logic [32:0] w_dx, w_dy;
    logic        w_neg, w_start, w_done, w_done_x, w_done_y;
    logic [30:0] w_xden, w_yden;
    logic [31:0] w_qx, w_qy;
    logic        w_read_out;
    logic        w_bin_out;

    assign w_cols = ({3'b0, r_ncols} > MC) ? MC : {3'b0, r_ncols};
    assign w_rows = ({3'b0, r_nrows} > MR) ? MR : {3'b0, r_nrows};
    assign w_dx   = {i_x_pos[31], i_x_pos} - {r_x_min[31], r_x_min};
    assign w_dy   = {i_y_pos[31], i_y_pos} - {r_y_min[31], r_y_min};
    assign w_neg  = w_dx[32] | w_dy[32];
    assign w_xden = (r_x_w == '0) ? 31'd1 : r_x_w;
    assign w_yden = (r_y_w == '0) ? 31'd1 : r_y_w;
    assign w_read_out = ({4'b0, i_read_col} >= w_cols) || ({4'b0, i_read_row} >= w_rows);
    assign w_bin_out  = (w_qx >= {21'b0, w_cols}) || (w_qy >= {21'b0, w_rows});
    assign w_done     = w_done_x && w_done_y;

    gbma_div #(.NW(32), .DW(31)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_dx[31:0]), .i_den(w_xden), .o_done(w_done_x), .o_quot(w_qx)
    );

    gbma_div #(.NW(32), .DW(31)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_dy[31:0]), .i_den(w_yden), .o_done(w_done_y), .o_quot(w_qy)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbma_pkg::FS_IDLE: begin
                if (i_take) begin
                    n_state = (i_func == gbma_pkg::FUNC_ADD && !w_neg) ?
                              gbma_pkg::FS_DIV : gbma_pkg::FS_SEND;
                end
            end
            gbma_pkg::FS_DIV: begin
                if (w_done) begin
                    n_state = gbma_pkg::FS_SEND;
                end
            end
            gbma_pkg::FS_SEND: begin
                if (!i_q_full) begin
                    n_state = gbma_pkg::FS_IDLE;
                end
            end
            default: n_state = gbma_pkg::FS_IDLE;
        endcase
    end

    always_comb begin
        w_start = (r_state == gbma_pkg::FS_IDLE) && i_take &&
                  (i_func == gbma_pkg::FUNC_ADD) && !w_neg;
        o_push  = (r_state == gbma_pkg::FS_SEND) && !i_q_full;
        o_busy  = (r_state != gbma_pkg::FS_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbma_pkg::FS_IDLE;
            r_x_min <= '0;
            r_y_min <= '0;
            r_x_w   <= 31'd65536;
            r_y_w   <= 31'd65536;
            r_ncols <= 8'd128;
            r_nrows <= 8'd128;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gbma_pkg::CFG_X_MIN:    r_x_min <= i_cfg_data;
                    gbma_pkg::CFG_Y_MIN:    r_y_min <= i_cfg_data;
                    gbma_pkg::CFG_X_WIDTH:  r_x_w   <= i_cfg_data[30:0];
                    gbma_pkg::CFG_Y_WIDTH:  r_y_w   <= i_cfg_data[30:0];
                    gbma_pkg::CFG_NUM_COLS: r_ncols <= i_cfg_data[7:0];
                    gbma_pkg::CFG_NUM_ROWS: r_nrows <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gbma_pkg::FS_IDLE && i_take) begin
            r_cmd.value   <= i_sample_value;
            r_cmd.idx     <= gbma_pkg::CELL_IDX_W'(i_read_col) *
                             gbma_pkg::CELL_IDX_W'(MAX_ROWS) +
                             gbma_pkg::CELL_IDX_W'(i_read_row);
            unique case (i_func)
                gbma_pkg::FUNC_ADD: begin
                    r_cmd.op      <= w_neg ? gbma_pkg::OP_NOP : gbma_pkg::OP_ADD;
                    r_cmd.dropped <= w_neg;
                end
                gbma_pkg::FUNC_READ: begin
                    r_cmd.op      <= w_read_out ? gbma_pkg::OP_EMPTY : gbma_pkg::OP_READ;
                    r_cmd.dropped <= 1'b0;
                end
                gbma_pkg::FUNC_CLEAR: begin
                    r_cmd.op      <= gbma_pkg::OP_CLEAR;
                    r_cmd.dropped <= 1'b0;
                end
                default: begin
                    r_cmd.op      <= gbma_pkg::OP_NOP;
                    r_cmd.dropped <= 1'b0;
                end
            endcase
        end else if (r_state == gbma_pkg::FS_DIV && w_done) begin
            r_cmd.idx <= gbma_pkg::CELL_IDX_W'(w_qx) * gbma_pkg::CELL_IDX_W'(MAX_ROWS) +
                         gbma_pkg::CELL_IDX_W'(w_qy);
            if (w_bin_out) begin
                r_cmd.op      <= gbma_pkg::OP_NOP;
                r_cmd.dropped <= 1'b1;
            end
        end
    end

    assign o_cmd = r_cmd;

endmodule

// File: sv/gbma_cmdq.sv
// Two-entry request queue between the front and back ends.
module gbma_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gbma_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output gbma_pkg::t_cmd o_cmd
);

    gbma_pkg::t_cmd r_buf [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wp] <= i_cmd;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_buf[r_rp];

endmodule

// File: sv/gbma_back.sv
// Back end: cell memory update, mean division, clearing sweep and result register.
module gbma_back #(
    parameter int MAX_COLS = gbma_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gbma_pkg::DEF_MAX_ROWS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  gbma_pkg::t_cmd i_cmd,
    output logic           o_q_pop,
    output logic           o_clearing,
    input  logic           i_pop,
    output logic           o_valid,
    output gbma_pkg::t_res o_res
);

    localparam int NCELLS = MAX_COLS * MAX_ROWS;
    localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int SW     = gbma_pkg::SUM_W;
    localparam int CW     = gbma_pkg::CNT_W;
    localparam int MW     = SW + CW;
    localparam int VW     = gbma_pkg::VAL_W;

    gbma_pkg::t_bstate r_state, n_state;
    gbma_pkg::t_cmd    r_cmd;
    gbma_pkg::t_res    r_res, r_out;
    logic              r_valid;
    logic              r_reply;
    logic [AW-1:0]     r_clr_addr;

    logic [MW-1:0] r_mem [NCELLS];
    logic [MW-1:0] r_rdata;

    logic              w_we, w_div_start, w_load, w_div_done, w_clr_last;
    logic [AW-1:0]     w_waddr;
    logic [MW-1:0]     w_wdata;
    logic signed [SW-1:0] w_sum;
    logic [CW-1:0]     w_cnt, w_cnt_n;
    logic [SW:0]       w_sum_x;
    logic [SW-1:0]     w_sum_n, w_mag, w_quot;
    logic [31:0]       w_mean;

    assign w_sum   = r_rdata[MW-1:CW];
    assign w_cnt   = r_rdata[CW-1:0];
    assign w_cnt_n = (w_cnt == '1) ? w_cnt : w_cnt + 1'b1;
    assign w_sum_x = {w_sum[SW-1], w_sum} + {{(SW+1-VW){r_cmd.value[VW-1]}}, r_cmd.value};
    assign w_sum_n = (w_sum_x[SW] != w_sum_x[SW-1]) ?
                     {w_sum_x[SW], {(SW-1){~w_sum_x[SW]}}} : w_sum_x[SW-1:0];
    assign w_mag   = w_sum[SW-1] ? (~w_sum + 1'b1) : w_sum;
    assign w_clr_last = (r_clr_addr == AW'(NCELLS - 1));

    always_comb begin
        w_mean = 32'h0;
        if (w_sum[SW-1]) begin
            w_mean = (w_quot > SW'(32'h8000_0000)) ? 32'h8000_0000 : (~w_quot[31:0] + 1'b1);
        end else begin
            w_mean = (w_quot > SW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : w_quot[31:0];
        end
    end

    gbma_div #(.NW(SW), .DW(CW)) u_div_mean (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_mag), .i_den(w_cnt), .o_done(w_div_done), .o_quot(w_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbma_pkg::BS_CLEAR: begin
                if (w_clr_last) n_state = r_reply ? gbma_pkg::BS_DONE : gbma_pkg::BS_IDLE;
            end
            gbma_pkg::BS_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_cmd.op)
                        gbma_pkg::OP_ADD, gbma_pkg::OP_READ: n_state = gbma_pkg::BS_READ;
                        gbma_pkg::OP_CLEAR:                  n_state = gbma_pkg::BS_CLEAR;
                        default:                             n_state = gbma_pkg::BS_DONE;
                    endcase
                end
            end
            gbma_pkg::BS_READ: n_state = gbma_pkg::BS_EXEC;
            gbma_pkg::BS_EXEC: begin
                n_state = (r_cmd.op == gbma_pkg::OP_READ && w_cnt != '0) ?
                          gbma_pkg::BS_DIV : gbma_pkg::BS_DONE;
            end
            gbma_pkg::BS_DIV: begin
                if (w_div_done) n_state = gbma_pkg::BS_DONE;
            end
            gbma_pkg::BS_DONE: begin
                if (!r_valid || i_pop) n_state = gbma_pkg::BS_IDLE;
            end
            default: n_state = gbma_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop     = (r_state == gbma_pkg::BS_IDLE) && !i_q_empty;
        o_clearing  = (r_state == gbma_pkg::BS_CLEAR);
        w_we        = (r_state == gbma_pkg::BS_CLEAR) ||
                      (r_state == gbma_pkg::BS_EXEC && r_cmd.op == gbma_pkg::OP_ADD);
        w_div_start = (r_state == gbma_pkg::BS_EXEC) && (r_cmd.op == gbma_pkg::OP_READ) &&
                      (w_cnt != '0);
        w_load      = (r_state == gbma_pkg::BS_DONE) && (!r_valid || i_pop);
        w_waddr     = o_clearing ? r_clr_addr : r_cmd.idx[AW-1:0];
        w_wdata     = o_clearing ? '0 : {w_sum_n, w_cnt_n};
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[r_cmd.idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gbma_pkg::BS_CLEAR;
            r_reply    <= 1'b0;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_clearing) r_clr_addr <= w_clr_last ? '0 : r_clr_addr + 1'b1;
            if (o_q_pop) r_reply <= 1'b1;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_cmd;
            r_res <= '{mean_value: '0,
                       cell_empty: (i_cmd.op == gbma_pkg::OP_EMPTY),
                       cell_count: '0,
                       sample_dropped: i_cmd.dropped};
        end else if (r_state == gbma_pkg::BS_EXEC) begin
            if (r_cmd.op == gbma_pkg::OP_ADD) begin
                r_res.cell_count <= w_cnt_n;
            end else begin
                r_res.cell_count <= w_cnt;
                r_res.cell_empty <= (w_cnt == '0);
            end
        end else if (r_state == gbma_pkg::BS_DIV && w_div_done) begin
            r_res.mean_value <= w_mean;
        end
        if (w_load) r_out <= r_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_out;

endmodule

// File: sv/grid_binning_mean_accumulator_top.sv
// Top level of the grid binning mean accumulator.
// After reset a clearing sweep over all MAX_COLS*MAX_ROWS cells runs with full high; a clear
// request runs the same sweep before its result. The time of an add request is set by the
// 32-step bin index divider, that of a read of a filled cell by the 56-step mean divider.
// One request is in the front end at a time, two wait in the queue, one result waits in the
// output register.
module grid_binning_mean_accumulator_top #(
    parameter int MAX_COLS = gbma_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gbma_pkg::DEF_MAX_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gbma_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gbma_pkg::VAL_W-1:0]        i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_func,
    input  logic signed [31:0]                i_x_pos,
    input  logic signed [31:0]                i_y_pos,
    input  logic signed [31:0]                i_sample_value,
    input  logic [6:0]                        i_read_col,
    input  logic [6:0]                        i_read_row,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [31:0]                o_mean_value,
    output logic                              o_cell_empty,
    output logic [23:0]                       o_cell_count,
    output logic                              o_sample_dropped
);

    logic           w_busy, w_clearing, w_push, w_q_full, w_q_empty, w_q_pop, w_valid;
    gbma_pkg::t_cmd w_cmd_in, w_cmd_out;
    gbma_pkg::t_res w_res;

    assign full = w_busy || w_clearing;

    gbma_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_take(push && !full), .i_func(i_func), .i_x_pos(i_x_pos), .i_y_pos(i_y_pos),
        .i_sample_value(i_sample_value), .i_read_col(i_read_col), .i_read_row(i_read_row),
        .i_q_full(w_q_full), .o_busy(w_busy), .o_push(w_push), .o_cmd(w_cmd_in)
    );

    gbma_cmdq u_cmdq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_cmd(w_cmd_in),
        .i_pop(w_q_pop), .o_full(w_q_full), .o_empty(w_q_empty), .o_cmd(w_cmd_out)
    );

    gbma_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_empty(w_q_empty), .i_cmd(w_cmd_out),
        .o_q_pop(w_q_pop), .o_clearing(w_clearing), .i_pop(pop),
        .o_valid(w_valid), .o_res(w_res)
    );

    assign empty            = !w_valid;
    assign o_mean_value     = w_res.mean_value;
    assign o_cell_empty     = w_res.cell_empty;
    assign o_cell_count     = w_res.cell_count;
    assign o_sample_dropped = w_res.sample_dropped;

endmodule

// File: sv/gbma_checker.sv
// Port-level checks of the grid binning mean accumulator, bound to the top level.
`include "assert_macros.svh"

module gbma_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               pop,
    input logic               empty,
    input logic signed [31:0] o_mean_value,
    input logic               o_cell_empty,
    input logic [23:0]        o_cell_count,
    input logic               o_sample_dropped
);

    logic w_shown, w_drop_ok, w_empty_ok;

    assign w_shown    = !empty;
    assign w_drop_ok  = (o_mean_value == 0) && !o_cell_empty && (o_cell_count == 0);
    assign w_empty_ok = (o_mean_value == 0) && (o_cell_count == 0) && !o_sample_dropped;

    `GBMA_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, w_shown && !pop, w_shown)
    `GBMA_ASSERT_NOW(a_drop_clean, i_clk, i_rst_n, w_shown && o_sample_dropped, w_drop_ok)
    `GBMA_ASSERT_NOW(a_empty_clean, i_clk, i_rst_n, w_shown && o_cell_empty, w_empty_ok)
    `GBMA_ASSERT_NOW(a_mean_counted, i_clk, i_rst_n, w_shown && o_mean_value != 0, o_cell_count != 0)

endmodule

bind grid_binning_mean_accumulator_top gbma_checker u_gbma_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .pop(pop), .empty(empty),
    .o_mean_value(o_mean_value), .o_cell_empty(o_cell_empty),
    .o_cell_count(o_cell_count), .o_sample_dropped(o_sample_dropped)
);
